### src/omc_pkg.sv
// ---------------------------------------------------------------------------
// omc_pkg: shared types and constants of the optimal merge cost block
// Holds the chain operation codes and the fixed port widths.
// ---------------------------------------------------------------------------
package omc_pkg;

  // Fixed field widths
  localparam int unsigned SIZE_W = 16;
  localparam int unsigned COST_W = 28;
  localparam logic [COST_W-1:0] COST_MAX = '1;

  // Operation applied to every cell of the sorted chain at once
  typedef enum logic [2:0] {
    OP_HOLD,
    OP_INSERT,
    OP_SHIFT,
    OP_SHIFT_INSERT,
    OP_CLEAR
  } chain_op_e;

  // Control group from the sequencer to the chain
  typedef struct packed {
    chain_op_e op;
  } chain_ctrl_t;

endpackage

### src/omc_cell.sv
// ---------------------------------------------------------------------------
// omc_cell: one slot of the sorted priority chain
// Holds one value and its valid bit; inserts a broadcast key in order and
// shifts toward the head on a pop, talking only to its two neighbors.
// ---------------------------------------------------------------------------
module omc_cell #(
  parameter int unsigned VAL_W = 22
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  omc_pkg::chain_ctrl_t ctrl_i,
  input  logic [VAL_W-1:0]     key_i,
  input  logic                 head_i,
  input  logic [VAL_W-1:0]     left_val_i,
  input  logic                 left_vld_i,
  input  logic [VAL_W-1:0]     right_val_i,
  input  logic                 right_vld_i,
  output logic [VAL_W-1:0]     val_o,
  output logic                 vld_o
);

  logic [VAL_W-1:0] val_q, val_d;
  logic             vld_q, vld_d;
  logic             shift, ins;
  logic [VAL_W-1:0] cur_val, prev_val;
  logic             cur_vld, prev_vld;
  logic             cur_le, prev_le;

  // Pick the view of the chain after an optional pop, then place the key
  always_comb begin
    shift = (ctrl_i.op == omc_pkg::OP_SHIFT) || (ctrl_i.op == omc_pkg::OP_SHIFT_INSERT);
    ins   = (ctrl_i.op == omc_pkg::OP_INSERT) || (ctrl_i.op == omc_pkg::OP_SHIFT_INSERT);
    cur_val  = shift ? right_val_i : val_q;
    cur_vld  = shift ? right_vld_i : vld_q;
    prev_val = shift ? val_q : left_val_i;
    prev_vld = shift ? vld_q : left_vld_i;
    // an invalid slot counts as larger than any key
    cur_le  = cur_vld && (cur_val <= key_i);
    prev_le = head_i || (prev_vld && (prev_val <= key_i));
    val_d = val_q;
    vld_d = vld_q;
    if (ctrl_i.op == omc_pkg::OP_CLEAR) begin
      vld_d = 1'b0;
    end else if (ins) begin
      if (cur_le) begin
        val_d = cur_val;
        vld_d = cur_vld;
      end else if (prev_le) begin
        val_d = key_i;
        vld_d = 1'b1;
      end else begin
        val_d = prev_val;
        vld_d = prev_vld;
      end
    end else if (shift) begin
      val_d = cur_val;
      vld_d = cur_vld;
    end
  end

  // Hold the slot
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    val_q <= val_d;
  end

  assign val_o = val_q;
  assign vld_o = vld_q;

endmodule

### src/omc_chain.sv
// ---------------------------------------------------------------------------
// omc_chain: row of sorted cells, smallest value at the head
// Links every cell to its neighbors and exposes the head slot.
// ---------------------------------------------------------------------------
module omc_chain #(
  parameter int unsigned DEPTH = 64,
  parameter int unsigned VAL_W = 22
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  omc_pkg::chain_ctrl_t ctrl_i,
  input  logic [VAL_W-1:0]     key_i,
  output logic [VAL_W-1:0]     head_val_o,
  output logic                 head_vld_o
);

  logic [VAL_W-1:0] val [DEPTH];
  logic             vld [DEPTH];

  // Build the row; the ends see an empty neighbor
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic [VAL_W-1:0] left_val, right_val;
    logic             left_vld, right_vld;

    if (i == 0) begin : g_first
      assign left_val = '0;
      assign left_vld = 1'b0;
    end else begin : g_mid_l
      assign left_val = val[i-1];
      assign left_vld = vld[i-1];
    end

    if (i == DEPTH - 1) begin : g_last
      assign right_val = '0;
      assign right_vld = 1'b0;
    end else begin : g_mid_r
      assign right_val = val[i+1];
      assign right_vld = vld[i+1];
    end

    omc_cell #(
      .VAL_W(VAL_W)
    ) u_cell (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .ctrl_i     (ctrl_i),
      .key_i      (key_i),
      .head_i     ((i == 0) ? 1'b1 : 1'b0),
      .left_val_i (left_val),
      .left_vld_i (left_vld),
      .right_val_i(right_val),
      .right_vld_i(right_vld),
      .val_o      (val[i]),
      .vld_o      (vld[i])
    );
  end

  assign head_val_o = val[0];
  assign head_vld_o = vld[0];

endmodule

### src/optimal_merge_cost_core.sv
// ---------------------------------------------------------------------------
// optimal_merge_cost_core: minimum total merge cost of a set of file sizes
// Keeps the sizes in a sorted chain of cells and merges the two smallest
// until one remains, then reports the accumulated cost.
// ---------------------------------------------------------------------------
// Usage: each size beat is taken while a set is loading. After the beat
// marked last_item_i the block is busy merging the n stored sizes, each merge
// a pop and then a combined pop-and-insert of the cell chain, and then
// presents one result beat. Once that beat is taken the chain is cleared in
// the same cycle and the next set may start on the following cycle. Sizes
// beyond CAPACITY are dropped and flagged in overflow_o; the cost saturates
// at 2^28-1.
module optimal_merge_cost_core #(
  parameter int unsigned CAPACITY  = 64,
  parameter int unsigned SIZE_BITS = 16
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_ready_o,
  input  logic [omc_pkg::SIZE_W-1:0] file_size_i,
  input  logic                       last_item_i,
  output logic                       out_valid_o,
  input  logic                       out_ready_i,
  output logic [omc_pkg::COST_W-1:0] total_cost_o,
  output logic                       overflow_o
);

  localparam int unsigned IN_W  = (SIZE_BITS < omc_pkg::SIZE_W) ? SIZE_BITS : omc_pkg::SIZE_W;
  localparam int unsigned VAL_W = SIZE_BITS + $clog2(CAPACITY);
  localparam int unsigned CNT_W = $clog2(CAPACITY + 1);
  localparam int unsigned SUM_W = ((VAL_W > omc_pkg::COST_W) ? VAL_W : omc_pkg::COST_W) + 1;

  typedef enum logic [1:0] {
    ST_LOAD,
    ST_POP_A,
    ST_POP_B,
    ST_OUT
  } state_e;

  state_e                     state_q, state_d;
  logic [CNT_W-1:0]           count_q, count_d;
  logic [omc_pkg::COST_W-1:0] acc_q, acc_d;
  logic                       drop_q, drop_d;
  logic [VAL_W-1:0]           a_q, a_d;

  omc_pkg::chain_ctrl_t ctrl;
  logic [VAL_W-1:0]     key;
  logic [VAL_W-1:0]     head_val;
  logic                 head_vld;
  logic                 fits;
  logic [CNT_W-1:0]     count_after;
  logic [VAL_W-1:0]     pair_sum;
  logic [SUM_W-1:0]     acc_sum;

  omc_chain #(
    .DEPTH(CAPACITY),
    .VAL_W(VAL_W)
  ) u_chain (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .ctrl_i    (ctrl),
    .key_i     (key),
    .head_val_o(head_val),
    .head_vld_o(head_vld)
  );

  // Sequence load, merge and result
  always_comb begin
    fits        = (count_q < CNT_W'(CAPACITY));
    count_after = count_q + CNT_W'(fits);
    pair_sum    = a_q + head_val;
    acc_sum     = SUM_W'(acc_q) + SUM_W'(pair_sum);
    ctrl.op     = omc_pkg::OP_HOLD;
    key         = VAL_W'(file_size_i[IN_W-1:0]);
    state_d     = state_q;
    count_d     = count_q;
    acc_d       = acc_q;
    drop_d      = drop_q;
    a_d         = a_q;
    unique case (state_q)
      ST_LOAD: begin
        if (in_valid_i) begin
          // insert the beat or drop it when the chain is full
          ctrl.op = fits ? omc_pkg::OP_INSERT : omc_pkg::OP_HOLD;
          count_d = count_after;
          drop_d  = drop_q | ~fits;
          if (last_item_i) begin
            state_d = (count_after > CNT_W'(1)) ? ST_POP_A : ST_OUT;
          end
        end
      end
      ST_POP_A: begin
        // take the smallest entry
        ctrl.op = omc_pkg::OP_SHIFT;
        a_d     = head_val;
        count_d = count_q - CNT_W'(1);
        state_d = ST_POP_B;
      end
      ST_POP_B: begin
        // take the next smallest and reinsert the pair sum
        ctrl.op = omc_pkg::OP_SHIFT_INSERT;
        key     = pair_sum;
        if (acc_sum > SUM_W'(omc_pkg::COST_MAX)) begin
          acc_d = omc_pkg::COST_MAX;
        end else begin
          acc_d = acc_sum[omc_pkg::COST_W-1:0];
        end
        state_d = (count_q > CNT_W'(1)) ? ST_POP_A : ST_OUT;
      end
      ST_OUT: begin
        if (out_ready_i) begin
          // clear for the next set
          ctrl.op = omc_pkg::OP_CLEAR;
          count_d = '0;
          acc_d   = '0;
          drop_d  = 1'b0;
          state_d = ST_LOAD;
        end
      end
      default: begin
        state_d = ST_LOAD;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_LOAD;
      count_q <= '0;
      acc_q   <= '0;
      drop_q  <= 1'b0;
      a_q     <= '0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      acc_q   <= acc_d;
      drop_q  <= drop_d;
      a_q     <= a_d;
    end
  end

  assign in_ready_o   = (state_q == ST_LOAD);
  assign out_valid_o  = (state_q == ST_OUT) && (head_vld || !head_vld);
  assign total_cost_o = acc_q;
  assign overflow_o   = drop_q;

endmodule

### src/omc_checker.sv
// ---------------------------------------------------------------------------
// omc_checker: port-level checks of the optimal merge cost block
// Watches the handshakes and the load / merge / result sequence.
// ---------------------------------------------------------------------------
module omc_checker (
  input logic                       clk_i,
  input logic                       rst_ni,
  input logic                       in_valid_i,
  input logic                       in_ready_o,
  input logic                       last_item_i,
  input logic                       out_valid_o,
  input logic                       out_ready_i,
  input logic [omc_pkg::COST_W-1:0] total_cost_o,
  input logic                       overflow_o
);

  // Hold a stalled result beat
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(total_cost_o) && $stable(overflow_o))
    else $error("result beat changed while stalled");

  // Never load while a result is pending
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !in_ready_o)
    else $error("input ready while result pending");

  // Keep loading after a beat that does not end the set
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && !last_item_i |=> in_ready_o && !out_valid_o)
    else $error("set ended early");

  // Stop loading after the last beat of a set
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && last_item_i |=> !in_ready_o)
    else $error("input taken after last beat");

  // Return to loading once the result is taken
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_ready_i |=> in_ready_o && !out_valid_o)
    else $error("not ready for next set");

endmodule

bind optimal_merge_cost_core omc_checker u_omc_checker (.*);

### test/testbench.sv
// ---------------------------------------------------------------------------
// testbench: self-checking bench for optimal_merge_cost_core
// Feeds sets of file sizes over a valid/ready channel, predicts the minimum
// merge cost and the overflow flag of each set, and compares every result
// beat against the oldest prediction. Both channels idle at random.
// ---------------------------------------------------------------------------
`timescale 1ns / 100ps

module testbench;

  localparam int unsigned SIZE_W      = omc_pkg::SIZE_W;
  localparam int unsigned COST_W      = omc_pkg::COST_W;
  localparam logic [COST_W-1:0] COST_MAX = omc_pkg::COST_MAX;

  localparam int unsigned CAPACITY    = 64;
  localparam int unsigned SIZE_BITS   = 16;
  localparam int unsigned ITEM_TARGET = 1850;
  localparam int unsigned TAIL_CYCLES = 200;
  localparam int unsigned HOLD_CYCLES = 300;
  localparam int unsigned HOLD_AFTER  = 30;
  localparam int unsigned QUIET_START = 3000;
  localparam int unsigned QUIET_END   = 5000;

  // Value ranges used when filling a set
  typedef enum int {
    SZ_ANY,
    SZ_TINY,
    SZ_HIGH,
    SZ_MAX
  } size_mode_e;

  typedef struct {
    logic [SIZE_W-1:0] file_size;
    logic              last_item;
    bit                drain_first;
  } size_beat_t;

  typedef struct {
    logic [COST_W-1:0] total_cost;
    logic              overflow;
  } merge_result_t;

  logic              clk_i;
  logic              rst_ni;
  logic              in_valid_i;
  logic              in_ready_o;
  logic [SIZE_W-1:0] file_size_i;
  logic              last_item_i;
  logic              out_valid_o;
  logic              out_ready_i;
  logic [COST_W-1:0] total_cost_o;
  logic              overflow_o;

  size_beat_t    size_beats_q[$];
  merge_result_t cost_expect_q[$];
  longint        set_sizes_q[$];
  bit            set_dropped;

  size_beat_t  next_beat;
  int unsigned issue_count;
  int unsigned accept_count;
  int unsigned total_beats;
  int unsigned results_seen;
  int unsigned cycle_count;
  int unsigned hold_left;
  bit          hold_done;
  int unsigned error_count;

  optimal_merge_cost_core #(
    .CAPACITY (CAPACITY),
    .SIZE_BITS(SIZE_BITS)
  ) u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .file_size_i (file_size_i),
    .last_item_i (last_item_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .total_cost_o(total_cost_o),
    .overflow_o  (overflow_o)
  );

  // Generate the clock
  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Print one mismatch line and count it
  task automatic report_mismatch(input string msg);
    $display("ERROR @%0t: %s", $realtime, msg);
    error_count++;
  endtask

  // Minimum merge cost of a set: merge the two smallest until one is left
  function automatic merge_result_t merge_set_cost(input longint sizes[$], input bit dropped);
    longint        pool[$];
    longint        a;
    longint        b;
    longint        acc;
    merge_result_t res;
    pool = sizes;
    acc  = 0;
    while (pool.size() > 1) begin
      pool.sort();
      a = pool.pop_front();
      b = pool.pop_front();
      acc += a + b;
      if (acc > longint'(COST_MAX)) acc = longint'(COST_MAX);
      pool.push_back(a + b);
    end
    res.total_cost = acc[COST_W-1:0];
    res.overflow   = dropped;
    return res;
  endfunction

  task automatic add_beat(input logic [SIZE_W-1:0] size, input logic last, input bit drain);
    size_beat_t beat;
    beat.file_size   = size;
    beat.last_item   = last;
    beat.drain_first = drain;
    size_beats_q.push_back(beat);
  endtask

  // Queue one set of n sizes drawn from the given range
  task automatic add_set(input int unsigned n, input size_mode_e mode, input bit drain);
    logic [SIZE_W-1:0] size;
    for (int unsigned i = 0; i < n; i++) begin
      case (mode)
        SZ_TINY: size = SIZE_W'($urandom_range(0, 15));
        SZ_HIGH: size = SIZE_W'($urandom_range(65000, 65535));
        SZ_MAX:  size = '1;
        default: size = SIZE_W'($urandom);
      endcase
      add_beat(size, i == n - 1, drain && i == 0);
    end
  endtask

  // Drive the size channel: hold an offered beat until it is taken
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && accept_count != issue_count) begin
        // hold the pending beat
      end else if (size_beats_q.size() != 0 &&
                   !(size_beats_q[0].drain_first && cost_expect_q.size() != 0) &&
                   ((cycle_count >= QUIET_START && cycle_count < QUIET_END) ||
                    $urandom_range(0, 99) >= 13)) begin
        next_beat = size_beats_q.pop_front();
        in_valid_i  <= 1'b1;
        file_size_i <= next_beat.file_size;
        last_item_i <= next_beat.last_item;
        issue_count++;
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // Drive the result ready: random stalls plus one long hold-off
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (hold_left != 0) begin
        hold_left--;
        out_ready_i <= 1'b0;
      end else if (!hold_done && results_seen >= HOLD_AFTER) begin
        hold_done = 1'b1;
        hold_left = HOLD_CYCLES - 1;
        out_ready_i <= 1'b0;
      end else if (cycle_count >= QUIET_START && cycle_count < QUIET_END) begin
        out_ready_i <= 1'b1;
      end else begin
        out_ready_i <= ($urandom_range(0, 99) >= 13);
      end
    end
  end

  // Predict on every accepted size beat and check every result beat
  always @(posedge clk_i) begin
    merge_result_t exp_res;
    if (rst_ni) begin
      cycle_count++;
      if (in_valid_i && in_ready_o) begin
        accept_count++;
        if (set_sizes_q.size() < CAPACITY) set_sizes_q.push_back(longint'(file_size_i));
        else set_dropped = 1'b1;
        if (last_item_i) begin
          cost_expect_q.push_back(merge_set_cost(set_sizes_q, set_dropped));
          set_sizes_q.delete();
          set_dropped = 1'b0;
        end
      end
      if (out_valid_o && out_ready_i) begin
        results_seen++;
        if (cost_expect_q.size() == 0) begin
          report_mismatch($sformatf("unexpected result beat cost=%0d overflow=%0b",
                                    total_cost_o, overflow_o));
        end else begin
          exp_res = cost_expect_q.pop_front();
          if (total_cost_o !== exp_res.total_cost)
            report_mismatch($sformatf("result %0d: total_cost %0d, expected %0d",
                                      results_seen, total_cost_o, exp_res.total_cost));
          if (overflow_o !== exp_res.overflow)
            report_mismatch($sformatf("result %0d: overflow %0b, expected %0b",
                                      results_seen, overflow_o, exp_res.overflow));
        end
      end
    end
  end

  // Build the stimulus, run reset, and wait for the end
  initial begin
    int unsigned pick;
    int unsigned n;
    size_mode_e  mode;
    rst_ni       = 1'b0;
    in_valid_i   = 1'b0;
    file_size_i  = '0;
    last_item_i  = 1'b0;
    out_ready_i  = 1'b0;
    issue_count  = 0;
    accept_count = 0;
    results_seen = 0;
    cycle_count  = 0;
    hold_left    = 0;
    hold_done    = 1'b0;
    error_count  = 0;
    set_dropped  = 1'b0;

    // Directed sets: lone extremes, max pair, zeros, ramp, patterns, ties
    add_beat('0, 1'b1, 1'b0);
    add_beat('1, 1'b1, 1'b0);
    add_beat('1, 1'b0, 1'b0);
    add_beat('1, 1'b1, 1'b0);
    add_beat('0, 1'b0, 1'b0);
    add_beat('0, 1'b0, 1'b0);
    add_beat('0, 1'b1, 1'b0);
    for (int unsigned i = 1; i <= 5; i++) add_beat(SIZE_W'(i), i == 5, 1'b0);
    add_beat(16'hAAAA, 1'b0, 1'b0);
    add_beat(16'h5555, 1'b1, 1'b0);
    for (int unsigned i = 0; i < 4; i++) add_beat(SIZE_W'(7), i == 3, 1'b0);

    // Full max-size store after a drain, overflowing max and random stores
    add_set(CAPACITY, SZ_MAX, 1'b1);
    add_set(CAPACITY + 2, SZ_MAX, 1'b0);
    add_set(CAPACITY + 1, SZ_ANY, 1'b0);

    // Random sets, mostly small
    while (size_beats_q.size() < ITEM_TARGET) begin
      pick = $urandom_range(0, 99);
      if (pick < 70) n = $urandom_range(1, 8);
      else if (pick < 90) n = $urandom_range(9, 40);
      else if (pick < 95) n = $urandom_range(41, CAPACITY);
      else n = $urandom_range(CAPACITY + 1, CAPACITY + 8);
      pick = $urandom_range(0, 99);
      if (pick < 60) mode = SZ_ANY;
      else if (pick < 80) mode = SZ_TINY;
      else if (pick < 95) mode = SZ_HIGH;
      else mode = SZ_MAX;
      add_set(n, mode, $urandom_range(0, 99) < 2);
    end
    total_beats = size_beats_q.size();

    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    while (accept_count != total_beats) @(posedge clk_i);
    while (cost_expect_q.size() != 0) @(posedge clk_i);
    repeat (TAIL_CYCLES) @(posedge clk_i);

    if (cost_expect_q.size() != 0)
      report_mismatch($sformatf("%0d expected results never arrived", cost_expect_q.size()));
    if (error_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  // End the run if it hangs
  initial begin
    #3_000_000;
    $display("CHECK FAILED");
    $finish;
  end

endmodule

### files.f
src/omc_pkg.sv
src/omc_cell.sv
src/omc_chain.sv
src/optimal_merge_cost_core.sv
src/omc_checker.sv
test/testbench.sv
